// ===== rtl/oaht_pkg.sv =====
// shared types and constants for the open addressing hash table
`default_nettype none

package oaht_pkg;

  // table geometry
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned FILL_W   = 8;
  localparam int unsigned CMP_W    = (CNT_W > FILL_W) ? CNT_W : FILL_W;
  localparam logic [FILL_W-1:0] FILL_RESET = 8'd192;

  // integer mix: number of shift/xor and shift/subtract steps
  localparam int unsigned HASH_STEPS = 7;
  localparam int unsigned HSTEP_W    = $clog2(HASH_STEPS);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
  } out_item_t;

  typedef struct packed {
    logic        tomb;
    logic [31:0] key;
    logic [31:0] value;
  } slot_word_t;

  typedef struct packed {
    logic       rd_en;
    idx_t       rd_addr;
    logic       wr_en;
    idx_t       wr_addr;
    slot_word_t wr_data;
  } ram_req_t;

  typedef struct packed {
    logic       vld;
    slot_word_t word;
  } ram_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/oaht_hash.sv =====
// iterative integer mix unit, one shift/xor or shift/subtract step per cycle
`default_nettype none

module oaht_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] key_i,
  output logic             done_o,
  output logic [31:0]      hash_o
);

  localparam logic [oaht_pkg::HSTEP_W-1:0] LastStep =
    oaht_pkg::HSTEP_W'(oaht_pkg::HASH_STEPS - 1);

  logic [31:0]                  a_q;
  logic [oaht_pkg::HSTEP_W-1:0] step_q;
  logic                         busy_q;
  logic                         done_q;

  logic [4:0]  shamt;
  logic        shl;
  logic        sub;
  logic [31:0] shifted;
  logic [31:0] res;

  // step table
  always_comb begin
    shamt = 5'd0;
    shl   = 1'b0;
    sub   = 1'b0;
    case (step_q)
      3'd0: begin shamt = 5'd6;  shl = 1'b1; sub = 1'b1; end
      3'd1: begin shamt = 5'd17; shl = 1'b0; sub = 1'b0; end
      3'd2: begin shamt = 5'd9;  shl = 1'b1; sub = 1'b1; end
      3'd3: begin shamt = 5'd4;  shl = 1'b1; sub = 1'b0; end
      3'd4: begin shamt = 5'd3;  shl = 1'b1; sub = 1'b1; end
      3'd5: begin shamt = 5'd10; shl = 1'b1; sub = 1'b0; end
      3'd6: begin shamt = 5'd15; shl = 1'b0; sub = 1'b0; end
      default: begin shamt = 5'd0; shl = 1'b0; sub = 1'b0; end
    endcase
  end

  // shared shifter and subtract/xor
  assign shifted = shl ? (a_q << shamt) : (a_q >> shamt);
  assign res     = sub ? (a_q - shifted) : (a_q ^ shifted);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= key_i;
    end else if (busy_q) begin
      a_q <= res;
    end
  end

  assign done_o = done_q;
  assign hash_o = a_q;

endmodule

`default_nettype wire

// ===== rtl/oaht_slot_ram.sv =====
// slot store: key, value and tombstone memory with per-slot valid bits
`default_nettype none

module oaht_slot_ram (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire oaht_pkg::ram_req_t req_i,
  output oaht_pkg::ram_rsp_t      rsp_o
);

  oaht_pkg::slot_word_t          mem [oaht_pkg::CAPACITY];
  logic [oaht_pkg::CAPACITY-1:0] vld_q;
  oaht_pkg::ram_rsp_t            rsp_q;

  // valid bits: a slot never written reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rsp_q.vld  <= vld_q[req_i.rd_addr];
      rsp_q.word <= mem[req_i.rd_addr];
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/open_addressing_hash_table.sv =====
// top level: linear probing hash map, 32-bit keys to 32-bit values, with tombstones
// probe walk: k slots probed per item, k from 1 to CAPACITY
// the 7 mix steps run on one shared shift unit, then one slot read per cycle
// a new item is taken only once the previous one has been committed to the result register
// reset: asynchronous, active low; all slots empty, used count zero, fill limit 192
`default_nettype none

module open_addressing_hash_table (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire oaht_pkg::in_item_t  in_item_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output oaht_pkg::out_item_t      out_item_o,
  // fill limit write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [oaht_pkg::FILL_W-1:0] cfg_data_i
);

  localparam logic [oaht_pkg::CNT_W-1:0] LastProbe =
    oaht_pkg::CNT_W'(oaht_pkg::CAPACITY - 1);

  // sequencer state
  oaht_pkg::state_e state_q, state_d;

  // item being worked on
  oaht_pkg::in_item_t item_q;

  // probe walk
  oaht_pkg::idx_t               idx_q, idx_d;
  logic [oaht_pkg::CNT_W-1:0]   probes_q, probes_d;
  logic                         tomb_seen_q, tomb_seen_d;
  oaht_pkg::idx_t               tomb_idx_q, tomb_idx_d;

  // table bookkeeping and config
  logic [oaht_pkg::CNT_W-1:0]   used_q, used_d;
  logic [oaht_pkg::FILL_W-1:0]  fill_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  oaht_pkg::out_item_t  out_item_q, out_item_d;

  logic accept;
  logic out_accept;
  logic out_free;
  logic hash_done;
  logic [31:0] hash;

  oaht_pkg::ram_req_t ram_req;
  oaht_pkg::ram_rsp_t ram_rsp;

  // slot decode of the word read last cycle
  logic           slot_live;
  logic           slot_tomb;
  logic           slot_empty;
  logic           hit_match;
  logic           last_probe;
  logic           run_end;
  logic           tomb_any;
  oaht_pkg::idx_t tomb_at;
  logic           limit_hit;
  logic           commit;

  assign accept      = in_valid_i && !in_stall_o;
  assign out_accept  = out_valid_q && !out_stall_i;
  // a finished result may only land when the output register is empty or draining
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != oaht_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // shared mix unit
  oaht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (in_item_i.key),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  // slot store
  oaht_slot_ram u_slot_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ram_req),
    .rsp_o  (ram_rsp)
  );

  assign slot_empty = !ram_rsp.vld;
  assign slot_live  = ram_rsp.vld && !ram_rsp.word.tomb;
  assign slot_tomb  = ram_rsp.vld && ram_rsp.word.tomb;
  assign hit_match  = slot_live && (ram_rsp.word.key == item_q.key);
  assign last_probe = (probes_q == LastProbe);
  // the walk stops on a live match, on an empty slot, or after a full lap
  assign run_end    = hit_match || slot_empty || last_probe;

  // first tombstone of the run, the current slot included
  assign tomb_any = tomb_seen_q || slot_tomb;
  assign tomb_at  = tomb_seen_q ? tomb_idx_q : idx_q;

  // taking one more empty slot would pass the fill limit
  assign limit_hit = (oaht_pkg::CMP_W'(used_q) >= oaht_pkg::CMP_W'(fill_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      oaht_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = oaht_pkg::ST_HASH;
        end
      end
      oaht_pkg::ST_HASH: begin
        if (hash_done) begin
          state_d = oaht_pkg::ST_PROBE;
        end
      end
      oaht_pkg::ST_PROBE: begin
        if (run_end && out_free) begin
          state_d = oaht_pkg::ST_IDLE;
        end
      end
      default: state_d = oaht_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: memory requests, walk bookkeeping, result
  always_comb begin
    ram_req     = '0;
    commit      = 1'b0;
    idx_d       = idx_q;
    probes_d    = probes_q;
    tomb_seen_d = tomb_seen_q;
    tomb_idx_d  = tomb_idx_q;
    used_d      = used_q;
    out_item_d  = out_item_q;
    case (state_q)
      oaht_pkg::ST_IDLE: begin
        if (accept) begin
          probes_d    = '0;
          tomb_seen_d = 1'b0;
        end
      end
      oaht_pkg::ST_HASH: begin
        // home slot read
        if (hash_done) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = hash[oaht_pkg::IDX_W-1:0];
          idx_d           = hash[oaht_pkg::IDX_W-1:0];
        end
      end
      oaht_pkg::ST_PROBE: begin
        if (!run_end) begin
          // step to the next slot with wrap-around
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = oaht_pkg::idx_t'(idx_q + 1'b1);
          idx_d           = oaht_pkg::idx_t'(idx_q + 1'b1);
          probes_d        = probes_q + 1'b1;
          if (slot_tomb && !tomb_seen_q) begin
            tomb_seen_d = 1'b1;
            tomb_idx_d  = idx_q;
          end
        end else if (out_free) begin
          commit                 = 1'b1;
          out_item_d.status      = oaht_pkg::STATUS_ABSENT;
          out_item_d.found_value = '0;
          ram_req.wr_data.tomb   = 1'b0;
          ram_req.wr_data.key    = item_q.key;
          ram_req.wr_data.value  = item_q.value;
          case (item_q.op)
            oaht_pkg::OP_LOOKUP: begin
              if (hit_match) begin
                out_item_d.status      = oaht_pkg::STATUS_OK;
                out_item_d.found_value = ram_rsp.word.value;
              end
            end
            oaht_pkg::OP_INSERT: begin
              if (hit_match) begin
                // update in place
                ram_req.wr_en     = 1'b1;
                ram_req.wr_addr   = idx_q;
                out_item_d.status = oaht_pkg::STATUS_OK;
              end else if (tomb_any) begin
                // reuse the first tombstone, count unchanged
                ram_req.wr_en     = 1'b1;
                ram_req.wr_addr   = tomb_at;
                out_item_d.status = oaht_pkg::STATUS_OK;
              end else if (slot_empty && !limit_hit) begin
                ram_req.wr_en     = 1'b1;
                ram_req.wr_addr   = idx_q;
                used_d            = used_q + 1'b1;
                out_item_d.status = oaht_pkg::STATUS_OK;
              end else begin
                // over the fill limit, or a full lap with no free slot
                out_item_d.status = oaht_pkg::STATUS_FULL;
              end
            end
            oaht_pkg::OP_DELETE: begin
              if (hit_match) begin
                ram_req.wr_en          = 1'b1;
                ram_req.wr_addr        = idx_q;
                ram_req.wr_data.tomb   = 1'b1;
                ram_req.wr_data.value  = ram_rsp.word.value;
                out_item_d.status      = oaht_pkg::STATUS_OK;
                out_item_d.found_value = ram_rsp.word.value;
              end
            end
            default: begin
              // unused operation code: reported as absent, table untouched
              out_item_d.status = oaht_pkg::STATUS_ABSENT;
            end
          endcase
        end
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaht_pkg::ST_IDLE;
      used_q      <= '0;
      fill_q      <= oaht_pkg::FILL_RESET;
      out_valid_q <= 1'b0;
      tomb_seen_q <= 1'b0;
      probes_q    <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      tomb_seen_q <= tomb_seen_d;
      probes_q    <= probes_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fill_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    idx_q      <= idx_d;
    tomb_idx_q <= tomb_idx_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a result only appears at the end of a probe walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == oaht_pkg::ST_PROBE))
    else $error("result raised outside the probe walk");

  // the mix unit finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (state_q == oaht_pkg::ST_HASH))
    else $error("hash finished outside the hash phase");

  // the used count never reaches the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q < oaht_pkg::CNT_W'(oaht_pkg::CAPACITY))
    else $error("used slot count out of range");

  // the table is written only when an item completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.wr_en |=> out_valid_q && (state_q == oaht_pkg::ST_IDLE))
    else $error("slot written without a result");

endmodule

`default_nettype wire

// ===== bench/hash_table_checker.sv =====
// result checker for the hash table: keeps its own copy of the map and compares every result
`timescale 1ns / 1ps

module hash_table_checker
  import oaht_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_item_t          in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_item_t         out_item_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [FILL_W-1:0] cfg_data_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       refused_o,
  output int unsigned       longest_probe_o
);

  typedef enum logic [1:0] {
    SLOT_FREE,
    SLOT_HELD,
    SLOT_GRAVE
  } slot_e;

  typedef struct {
    in_item_t  req;
    out_item_t res;
  } awaited_t;

  slot_e             slot_st  [CAPACITY];
  logic [31:0]       slot_key [CAPACITY];
  logic [31:0]       slot_val [CAPACITY];
  logic [CNT_W-1:0]  occupied;
  logic [FILL_W-1:0] fill_limit;
  awaited_t          awaited_q [$];

  // seven-step shift/xor and shift/subtract integer mix
  function automatic logic [31:0] mix32(input logic [31:0] a);
    a = a - (a << 6);
    a = a ^ (a >> 17);
    a = a - (a << 9);
    a = a ^ (a << 4);
    a = a - (a << 3);
    a = a ^ (a << 10);
    a = a ^ (a >> 15);
    return a;
  endfunction

  task automatic clear_table();
    int unsigned i;
    for (i = 0; i < CAPACITY; i++) begin
      slot_st[i]  = SLOT_FREE;
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
    occupied   = '0;
    fill_limit = FILL_RESET;
  endtask

  // walks the probe run and applies the operation to the copy of the table
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t   res;
    logic [31:0] mixed;
    idx_t        idx;
    int          hit;
    int          grave;
    int          hole;
    int unsigned probes;
    res.status      = STATUS_ABSENT;
    res.found_value = '0;
    mixed  = mix32(req.key);
    idx    = mixed[IDX_W-1:0];
    hit    = -1;
    grave  = -1;
    hole   = -1;
    probes = 0;
    // reserved op code does not touch the table
    if (req.op inside {OP_LOOKUP, OP_INSERT, OP_DELETE}) begin
      while (hit < 0 && hole < 0 && probes < CAPACITY) begin
        probes++;
        case (slot_st[idx])
          SLOT_HELD:  if (slot_key[idx] == req.key) hit = int'(idx);
          SLOT_GRAVE: if (grave < 0) grave = int'(idx);
          default:    hole = int'(idx);
        endcase
        idx = idx + 1'b1;
      end
      if (probes > longest_probe_o) longest_probe_o = probes;
    end
    case (req.op)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          res.status      = STATUS_OK;
          res.found_value = slot_val[hit];
        end
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          slot_val[hit] = req.value;
          res.status    = STATUS_OK;
        end else if (grave >= 0) begin
          // first tombstone on the run is brought back to life, count unchanged
          slot_st[grave]  = SLOT_HELD;
          slot_key[grave] = req.key;
          slot_val[grave] = req.value;
          res.status      = STATUS_OK;
        end else if (hole < 0 || int'(occupied) + 1 > int'(fill_limit)) begin
          res.status = STATUS_FULL;
        end else begin
          slot_st[hole]  = SLOT_HELD;
          slot_key[hole] = req.key;
          slot_val[hole] = req.value;
          occupied       = occupied + 1'b1;
          res.status     = STATUS_OK;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          res.found_value = slot_val[hit];
          slot_st[hit]    = SLOT_GRAVE;
          res.status      = STATUS_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic compare_result(input out_item_t got);
    awaited_t want;
    if (awaited_q.size() == 0) begin
      error_count_o++;
      $display("%0t: result with nothing outstanding, status %0d value %h",
               $time, got.status, got.found_value);
    end else begin
      want = awaited_q.pop_front();
      checked_o++;
      if (got.status !== want.res.status) begin
        error_count_o++;
        $display("%0t: status wrong for op %0d key %h: expected %0d, got %0d",
                 $time, want.req.op, want.req.key, want.res.status, got.status);
      end
      if (got.found_value !== want.res.found_value) begin
        error_count_o++;
        $display("%0t: value wrong for op %0d key %h: expected %h, got %h",
                 $time, want.req.op, want.req.key, want.res.found_value, got.found_value);
      end
    end
  endtask

  task automatic record_request(input in_item_t req);
    awaited_t entry;
    entry.req = req;
    entry.res = apply_request(req);
    if (entry.res.status == STATUS_FULL) refused_o++;
    awaited_q.push_back(entry);
  endtask

  // results first, so a result never pairs with the item taken in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      awaited_q.delete();
      error_count_o   = 0;
      pending_o       = 0;
      checked_o       = 0;
      refused_o       = 0;
      longest_probe_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_item_i);
      if (cfg_valid_i && cfg_ready_i) fill_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) record_request(in_item_i);
      pending_o = awaited_q.size();
    end
  end

endmodule

// ===== bench/open_addressing_hash_table_tb.sv =====
// testbench top for the open addressing hash table: stimulus, idling and the verdict
`timescale 1ns / 1ps

module open_addressing_hash_table_tb;
  import oaht_pkg::*;

  localparam logic [1:0]  OP_RESERVED    = 2'd3;
  localparam int unsigned POOL_N         = 320;
  // the worst probe run reads all 256 slots; allow for long gaps and stalls on top
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned END_SETTLE     = 300;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [FILL_W-1:0] cfg_data_i  = '0;

  int unsigned error_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned refused;
  int unsigned longest_probe;
  int unsigned idle_cycles   = 0;
  int unsigned cycle_no      = 0;
  int unsigned stall_hold    = 0;
  int unsigned requests_sent = 0;
  logic [31:0] key_pool [POOL_N];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  open_addressing_hash_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  hash_table_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_i      (out_item_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .refused_o       (refused),
    .longest_probe_o (longest_probe)
  );

  // result side back-pressure: calm stretches, short bursts and the odd long stall
  always @(negedge clk_i) begin : stall_gen
    int unsigned roll;
    cycle_no++;
    if (cycle_no % 600 < 120) begin
      out_stall_i <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        out_stall_i <= 1'b0;
        stall_hold = $urandom_range(5);
      end else if (roll < 92) begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(2);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(40, 10);
      end
    end
  end

  // ends the run if no channel moves an item for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_req(input logic [1:0] op, input logic [31:0] key,
                                        input logic [31:0] value);
    in_item_t r;
    r.op    = op;
    r.key   = key;
    r.value = value;
    return r;
  endfunction

  // mostly known keys so that hits, updates and tombstones are common
  function automatic in_item_t random_req();
    in_item_t    r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45)      r.op = OP_INSERT;
    else if (roll < 75) r.op = OP_LOOKUP;
    else if (roll < 95) r.op = OP_DELETE;
    else                r.op = OP_RESERVED;
    if ($urandom_range(99) < 85) r.key = key_pool[$urandom_range(POOL_N - 1)];
    else                         r.key = $urandom;
    case ($urandom_range(19))
      0:       r.value = '0;
      1:       r.value = '1;
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (requests_sent % 300 < 60) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
    requests_sent++;
  endtask

  // register writes only once every outstanding result has come back
  task automatic write_fill_limit(input logic [FILL_W-1:0] limit);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_data_i  <= limit;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input logic [FILL_W-1:0] limit, input int unsigned count);
    in_item_t    req;
    int unsigned done;
    done = 0;
    write_fill_limit(limit);
    while (done < count) begin
      req = random_req();
      send_request(req);
      if (req.op != OP_RESERVED) done++;
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    for (i = 0; i < POOL_N; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill limit zero: nothing can take an empty slot
    write_fill_limit(8'd0);
    send_request(make_req(OP_INSERT, 32'h0000_0000, 32'hffff_ffff));
    send_request(make_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));

    // room for one slot: first insert lands, second is refused
    write_fill_limit(8'd1);
    send_request(make_req(OP_INSERT, 32'h0000_0000, 32'hffff_ffff));
    send_request(make_req(OP_INSERT, 32'hffff_ffff, 32'h0000_0000));
    send_request(make_req(OP_INSERT, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(OP_LOOKUP, 32'h0000_0000, 32'hffff_ffff));
    send_request(make_req(OP_DELETE, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(OP_DELETE, 32'h0000_0000, 32'h0000_0000));
    // the tombstone left behind is reused without touching the count
    send_request(make_req(OP_INSERT, 32'h0000_0000, 32'h5a5a_a5a5));
    send_request(make_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000));
    send_request(make_req(OP_RESERVED, 32'hffff_ffff, 32'hffff_ffff));

    // random phases, from the reset limit up to a nearly full table and back down
    run_random(FILL_RESET, 500);
    run_random(8'd255, 700);
    run_random(8'd1, 250);
    run_random(8'd0, 200);
    run_random(8'd128, 350);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);

    $display("run covered %0d requests across fill limits 0, 1, 128, 192 and 255",
             requests_sent);
    $display("%0d results checked, %0d inserts refused as full, longest probe run %0d slots",
             checked, refused, longest_probe);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/oaht_pkg.sv
rtl/oaht_hash.sv
rtl/oaht_slot_ram.sv
rtl/open_addressing_hash_table.sv
bench/hash_table_checker.sv
bench/open_addressing_hash_table_tb.sv
